>>> hdl/assert_macros.svh
// Assertion macros used by the checker of the tone pattern sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, switched off while reset is low.
`define TPS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// A stalled beat keeps its valid and its payload until it is taken.
`define TPS_ASSERT_HOLD(lbl, clk, rstn, vld, rdy, data, msg) \
  `TPS_ASSERT(lbl, clk, rstn, (vld && !rdy) |=> (vld && $stable(data)), msg)

`endif

>>> hdl/tps_pkg.sv
// Types and constants of the tone pattern sequencer.
`default_nettype none

package tps_pkg;

  localparam int unsigned PTR_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [15:0] RESET_COMPARE = 16'd3822;

  // Configuration register indices.
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = 2'd2;

  typedef enum logic [2:0] {
    ACT_STEP  = 3'd0,
    ACT_TIMER = 3'd1,
    ACT_PLAY  = 3'd2,
    ACT_STOP  = 3'd3,
    ACT_LOAD  = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [3:0]  note_index;
    logic [15:0] note_period;
    logic [7:0]  note_duration;
  } tps_in_t;

  typedef struct packed {
    logic       tone_level;
    logic       tone_running;
    logic       playing;
    logic [3:0] note_position;
    logic [7:0] passes_done;
  } tps_out_t;

  typedef struct packed {
    logic [15:0] period;
    logic [7:0]  duration;
  } tps_entry_t;

endpackage

`default_nettype wire

>>> hdl/tps_note_ram.sv
// Note table memory: one write port, two registered read ports with write bypass.
`default_nettype none

module tps_note_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AW-1:0]       waddr_i,
  input  wire tps_pkg::tps_entry_t wdata_i,
  input  wire logic [AW-1:0]       raddr_a_i,
  input  wire logic [AW-1:0]       raddr_b_i,
  output tps_pkg::tps_entry_t      rdata_a_o,
  output tps_pkg::tps_entry_t      rdata_b_o
);
  import tps_pkg::*;

  tps_entry_t mem [DEPTH];
  tps_entry_t rdata_a_q;
  tps_entry_t rdata_b_q;

  // A read of the entry being written returns the new contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_a_i)) begin
      rdata_a_q <= wdata_i;
    end else begin
      rdata_a_q <= mem[raddr_a_i];
    end
    if (we_i && (waddr_i == raddr_b_i)) begin
      rdata_b_q <= wdata_i;
    end else begin
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

>>> hdl/tone_pattern_sequencer_unit.sv
// Top level of the tone pattern sequencer: note table, sequencing counters and tone timer.
`default_nettype none

// The sequencer plays a table of up to MAX_NOTES notes as a square wave. Every input beat
// (step tick, timer tick, play, stop or load note) produces exactly one result beat, so
// the block sustains one beat per clock; the result leaves through an output register
// backed by a one-entry skid register, and input is refused only while both hold results
// that the sink has not taken. The note table sits in a synchronous memory with two read
// ports: one is always addressed by the next value of the note pointer and the other by
// the note that would follow it, so the entry of the current note and of its successor
// are both ready as soon as the pointer register takes its new value. That registered
// read, addressed ahead of the pointer, is what allows a note to end on every step tick
// without stalling. Loads that hit an entry being read are forwarded inside the memory, and
// the period of note 0 is mirrored in a register so that play can start the tone at once.
// Table entries are undefined until loaded; playing an unloaded note gives undefined
// periods and durations. Configuration writes are taken at any time with ready held high,
// but should only be issued while no beat is in flight.

module tone_pattern_sequencer_unit #(
  parameter int unsigned MAX_NOTES = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire tps_pkg::tps_in_t                   in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output tps_pkg::tps_out_t                       out_data_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [tps_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [tps_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import tps_pkg::*;

  localparam int unsigned AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
  localparam int unsigned XW = (AW > PTR_W) ? AW : PTR_W;
  localparam int unsigned MaxN = MAX_NOTES;

  // Successor of a note pointer, wrapping at the effective note count (zero counts as one)
  // and at the table depth.
  function automatic logic [PTR_W-1:0] succ_ptr(input logic [PTR_W-1:0] p,
                                               input logic [PTR_W-1:0] nc);
    logic [PTR_W-1:0] p1;
    logic [PTR_W-1:0] ncz;
    p1  = p + PTR_W'(1);
    ncz = (nc == '0) ? PTR_W'(1) : nc;
    if ((p1 >= ncz) || (32'(p1) >= MaxN)) begin
      return '0;
    end
    return p1;
  endfunction

  // Memory address of a note pointer; the pointer always stays below the table depth.
  function automatic logic [AW-1:0] to_addr(input logic [PTR_W-1:0] p);
    logic [XW-1:0] pe;
    pe = XW'(p);
    return pe[AW-1:0];
  endfunction

  // Configuration registers.
  logic [PTR_W-1:0] note_count_q, note_count_d;
  logic [7:0]       gap_ticks_q, gap_ticks_d;
  logic [7:0]       repeat_limit_q, repeat_limit_d;

  // Sequencing and timer state.
  logic [7:0]       dur_cnt_q, dur_cnt_d;
  logic [PTR_W-1:0] ptr_q, ptr_d;
  logic [7:0]       gap_cnt_q, gap_cnt_d;
  logic [7:0]       pass_q, pass_d;
  logic             active_q, active_d;
  logic             timer_en_q, timer_en_d;
  logic [15:0]      tcnt_q, tcnt_d;
  logic [15:0]      cmp_q, cmp_d;
  logic             level_q, level_d;
  logic [15:0]      zero_per_q;

  // Output register and skid register.
  tps_out_t out_q, out_d, skid_q, skid_d;
  logic     out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  tps_in_t    item;
  tps_entry_t cur_entry, nxt_entry, wr_entry;
  tps_out_t   result;
  logic       in_acc, out_pop, ld_en;
  logic       do_halt, do_tone, set_active, tone_gap;
  logic [15:0] tone_per;
  logic [7:0]  dur_inc, pass_inc;
  logic [PTR_W-1:0] ptr_succ;
  logic [AW-1:0] ra_cur, ra_nxt, wa;

  assign item        = in_data_i;
  assign in_ready_o  = !skid_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_pop     = out_valid_q && out_ready_i;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    note_count_d   = note_count_q;
    gap_ticks_d    = gap_ticks_q;
    repeat_limit_d = repeat_limit_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_NOTE_COUNT:   note_count_d   = cfg_data_i[PTR_W-1:0];
        CFG_GAP_TICKS:    gap_ticks_d    = cfg_data_i;
        CFG_REPEAT_LIMIT: repeat_limit_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign ptr_succ = succ_ptr(ptr_q, note_count_q);
  assign dur_inc  = dur_cnt_q + 8'd1;
  assign pass_inc = pass_q + 8'd1;

  // Next state for the accepted beat.
  always_comb begin
    dur_cnt_d  = dur_cnt_q;
    ptr_d      = ptr_q;
    gap_cnt_d  = gap_cnt_q;
    pass_d     = pass_q;
    active_d   = active_q;
    timer_en_d = timer_en_q;
    tcnt_d     = tcnt_q;
    cmp_d      = cmp_q;
    level_d    = level_q;
    ld_en      = 1'b0;
    do_halt    = 1'b0;
    do_tone    = 1'b0;
    set_active = 1'b0;
    tone_gap   = 1'b0;
    tone_per   = cur_entry.period;

    if (in_acc) begin
      case (item.action)
        ACT_STEP: begin
          if (active_q) begin
            if (gap_cnt_q != 8'd0) begin
              gap_cnt_d = gap_cnt_q - 8'd1;
              if (gap_cnt_q == 8'd1) begin
                do_tone  = 1'b1;
                tone_per = cur_entry.period;
              end
            end else if (dur_inc != cur_entry.duration) begin
              dur_cnt_d = dur_inc;
            end else begin
              // End of the note: move on, insert the gap and count a pass on wrap, stopping at the repeat limit.
              dur_cnt_d = 8'd0;
              ptr_d     = ptr_succ;
              gap_cnt_d = gap_ticks_q;
              tone_per  = nxt_entry.period;
              tone_gap  = (gap_ticks_q != 8'd0);
              if (ptr_succ == '0) begin
                pass_d = pass_inc;
                if (pass_inc == repeat_limit_q) begin
                  do_halt = 1'b1;
                end else begin
                  do_tone = 1'b1;
                end
              end else begin
                do_tone = 1'b1;
              end
            end
          end
        end
        ACT_TIMER: begin
          if (timer_en_q) begin
            if (tcnt_q == cmp_q) begin
              tcnt_d  = 16'd0;
              level_d = !level_q;
            end else begin
              tcnt_d = tcnt_q + 16'd1;
            end
          end
        end
        ACT_PLAY: begin
          do_halt    = 1'b1;
          set_active = 1'b1;
          do_tone    = 1'b1;
          tone_per   = zero_per_q;
        end
        ACT_STOP: begin
          do_halt = 1'b1;
        end
        ACT_LOAD: begin
          ld_en = (32'(item.note_index) < MaxN);
        end
        default: ;
      endcase
    end

    if (do_halt) begin
      dur_cnt_d  = 8'd0;
      ptr_d      = '0;
      pass_d     = 8'd0;
      gap_cnt_d  = 8'd0;
      active_d   = 1'b0;
      timer_en_d = 1'b0;
    end
    if (set_active) begin
      active_d = 1'b1;
    end
    if (do_tone) begin
      if ((tone_per == 16'd0) || tone_gap) begin
        timer_en_d = 1'b0;
      end else begin
        cmp_d      = tone_per;
        tcnt_d     = 16'd0;
        timer_en_d = 1'b1;
      end
    end
  end

  assign result.tone_level    = level_d;
  assign result.tone_running  = timer_en_d;
  assign result.playing       = active_d;
  assign result.note_position = ptr_d[3:0];
  assign result.passes_done   = pass_d;

  // Output register with a skid register behind it.
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_acc;
        out_d       = result;
      end
    end else if (in_acc) begin
      if (!out_valid_q) begin
        out_d       = result;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = result;
        skid_valid_d = 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The read ports follow the next pointer so that the table data lines up with it.
  assign ra_cur = to_addr(ptr_d);
  assign ra_nxt = to_addr(succ_ptr(ptr_d, note_count_d));
  assign wa     = AW'(item.note_index);
  assign wr_entry.period   = item.note_period;
  assign wr_entry.duration = item.note_duration;

  tps_note_ram #(
    .DEPTH (MAX_NOTES),
    .AW    (AW)
  ) u_note_ram (
    .clk_i     (clk_i),
    .we_i      (ld_en),
    .waddr_i   (wa),
    .wdata_i   (wr_entry),
    .raddr_a_i (ra_cur),
    .raddr_b_i (ra_nxt),
    .rdata_a_o (cur_entry),
    .rdata_b_o (nxt_entry)
  );

  // Copy of the period of note 0 for play.
  always_ff @(posedge clk_i) begin
    if (ld_en && (item.note_index == 4'd0)) begin
      zero_per_q <= item.note_period;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      note_count_q   <= PTR_W'(1);
      gap_ticks_q    <= 8'd0;
      repeat_limit_q <= 8'd1;
      dur_cnt_q      <= 8'd0;
      ptr_q          <= '0;
      gap_cnt_q      <= 8'd0;
      pass_q         <= 8'd0;
      active_q       <= 1'b0;
      timer_en_q     <= 1'b0;
      tcnt_q         <= 16'd0;
      cmp_q          <= RESET_COMPARE;
      level_q        <= 1'b0;
      out_valid_q    <= 1'b0;
      skid_valid_q   <= 1'b0;
    end else begin
      note_count_q   <= note_count_d;
      gap_ticks_q    <= gap_ticks_d;
      repeat_limit_q <= repeat_limit_d;
      dur_cnt_q      <= dur_cnt_d;
      ptr_q          <= ptr_d;
      gap_cnt_q      <= gap_cnt_d;
      pass_q         <= pass_d;
      active_q       <= active_d;
      timer_en_q     <= timer_en_d;
      tcnt_q         <= tcnt_d;
      cmp_q          <= cmp_d;
      level_q        <= level_d;
      out_valid_q    <= out_valid_d;
      skid_valid_q   <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

>>> hdl/tps_checker.sv
// Port checker of the tone pattern sequencer and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module tps_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire tps_pkg::tps_out_t out_data_o
);

  logic in_beat;
  logic idle_beat;
  logic idle_shown;

  assign in_beat    = in_valid_i && in_ready_o;
  assign idle_beat  = out_valid_o && !out_data_o.playing;
  assign idle_shown = (out_data_o.note_position == 4'd0) && (out_data_o.passes_done == 8'd0)
                      && !out_data_o.tone_running;

  `TPS_ASSERT_HOLD(a_hold, clk_i, rst_ni, out_valid_o, out_ready_i, out_data_o, "beat not held")

  // A beat taken while the output is empty is offered in the next cycle.
  `TPS_ASSERT(a_follows, clk_i, rst_ni, (in_beat && !out_valid_o) |=> out_valid_o, "no result")

  // Input is refused only when the output register holds a result as well.
  `TPS_ASSERT(a_ready_low, clk_i, rst_ni, !in_ready_o |-> out_valid_o, "stall with empty output")

  // When no pattern is active the sequencing counters are clear and the timer is off.
  `TPS_ASSERT(a_idle_clear, clk_i, rst_ni, idle_beat |-> idle_shown, "live state when idle")

endmodule

bind tone_pattern_sequencer_unit tps_checker u_tps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
